### design/assert_macros.svh
// Assertion macros used by the cipher's top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/aes_pkg.sv
package aes_pkg;

    localparam int NumRounds = 10;
    localparam int NumKeys   = NumRounds + 1;

    typedef logic [127:0] t_block;
    typedef logic [7:0]   t_byte;

    localparam logic [1:0] RegKeyHigh = 2'd0;
    localparam logic [1:0] RegKeyLow  = 2'd1;

    // Key schedule sequencer states.
    typedef enum logic [1:0] {
        t_ks_idle,
        t_ks_run
    } t_ks_state;

    // Control between key schedule and top level.
    typedef struct packed {
        logic busy;
        logic done;
    } t_ks_status;

    function automatic t_byte sbox_fwd(input t_byte a);
        t_byte s;
        unique case (a)
            8'h00: s=8'h63; 8'h01: s=8'h7C; 8'h02: s=8'h77; 8'h03: s=8'h7B;
            8'h04: s=8'hF2; 8'h05: s=8'h6B; 8'h06: s=8'h6F; 8'h07: s=8'hC5;
            8'h08: s=8'h30; 8'h09: s=8'h01; 8'h0A: s=8'h67; 8'h0B: s=8'h2B;
            8'h0C: s=8'hFE; 8'h0D: s=8'hD7; 8'h0E: s=8'hAB; 8'h0F: s=8'h76;
            8'h10: s=8'hCA; 8'h11: s=8'h82; 8'h12: s=8'hC9; 8'h13: s=8'h7D;
            8'h14: s=8'hFA; 8'h15: s=8'h59; 8'h16: s=8'h47; 8'h17: s=8'hF0;
            8'h18: s=8'hAD; 8'h19: s=8'hD4; 8'h1A: s=8'hA2; 8'h1B: s=8'hAF;
            8'h1C: s=8'h9C; 8'h1D: s=8'hA4; 8'h1E: s=8'h72; 8'h1F: s=8'hC0;
            8'h20: s=8'hB7; 8'h21: s=8'hFD; 8'h22: s=8'h93; 8'h23: s=8'h26;
            8'h24: s=8'h36; 8'h25: s=8'h3F; 8'h26: s=8'hF7; 8'h27: s=8'hCC;
            8'h28: s=8'h34; 8'h29: s=8'hA5; 8'h2A: s=8'hE5; 8'h2B: s=8'hF1;
            8'h2C: s=8'h71; 8'h2D: s=8'hD8; 8'h2E: s=8'h31; 8'h2F: s=8'h15;
            8'h30: s=8'h04; 8'h31: s=8'hC7; 8'h32: s=8'h23; 8'h33: s=8'hC3;
            8'h34: s=8'h18; 8'h35: s=8'h96; 8'h36: s=8'h05; 8'h37: s=8'h9A;
            8'h38: s=8'h07; 8'h39: s=8'h12; 8'h3A: s=8'h80; 8'h3B: s=8'hE2;
            8'h3C: s=8'hEB; 8'h3D: s=8'h27; 8'h3E: s=8'hB2; 8'h3F: s=8'h75;
            8'h40: s=8'h09; 8'h41: s=8'h83; 8'h42: s=8'h2C; 8'h43: s=8'h1A;
            8'h44: s=8'h1B; 8'h45: s=8'h6E; 8'h46: s=8'h5A; 8'h47: s=8'hA0;
            8'h48: s=8'h52; 8'h49: s=8'h3B; 8'h4A: s=8'hD6; 8'h4B: s=8'hB3;
            8'h4C: s=8'h29; 8'h4D: s=8'hE3; 8'h4E: s=8'h2F; 8'h4F: s=8'h84;
            8'h50: s=8'h53; 8'h51: s=8'hD1; 8'h52: s=8'h00; 8'h53: s=8'hED;
            8'h54: s=8'h20; 8'h55: s=8'hFC; 8'h56: s=8'hB1; 8'h57: s=8'h5B;
            8'h58: s=8'h6A; 8'h59: s=8'hCB; 8'h5A: s=8'hBE; 8'h5B: s=8'h39;
            8'h5C: s=8'h4A; 8'h5D: s=8'h4C; 8'h5E: s=8'h58; 8'h5F: s=8'hCF;
            8'h60: s=8'hD0; 8'h61: s=8'hEF; 8'h62: s=8'hAA; 8'h63: s=8'hFB;
            8'h64: s=8'h43; 8'h65: s=8'h4D; 8'h66: s=8'h33; 8'h67: s=8'h85;
            8'h68: s=8'h45; 8'h69: s=8'hF9; 8'h6A: s=8'h02; 8'h6B: s=8'h7F;
            8'h6C: s=8'h50; 8'h6D: s=8'h3C; 8'h6E: s=8'h9F; 8'h6F: s=8'hA8;
            8'h70: s=8'h51; 8'h71: s=8'hA3; 8'h72: s=8'h40; 8'h73: s=8'h8F;
            8'h74: s=8'h92; 8'h75: s=8'h9D; 8'h76: s=8'h38; 8'h77: s=8'hF5;
            8'h78: s=8'hBC; 8'h79: s=8'hB6; 8'h7A: s=8'hDA; 8'h7B: s=8'h21;
            8'h7C: s=8'h10; 8'h7D: s=8'hFF; 8'h7E: s=8'hF3; 8'h7F: s=8'hD2;
            8'h80: s=8'hCD; 8'h81: s=8'h0C; 8'h82: s=8'h13; 8'h83: s=8'hEC;
            8'h84: s=8'h5F; 8'h85: s=8'h97; 8'h86: s=8'h44; 8'h87: s=8'h17;
            8'h88: s=8'hC4; 8'h89: s=8'hA7; 8'h8A: s=8'h7E; 8'h8B: s=8'h3D;
            8'h8C: s=8'h64; 8'h8D: s=8'h5D; 8'h8E: s=8'h19; 8'h8F: s=8'h73;
            8'h90: s=8'h60; 8'h91: s=8'h81; 8'h92: s=8'h4F; 8'h93: s=8'hDC;
            8'h94: s=8'h22; 8'h95: s=8'h2A; 8'h96: s=8'h90; 8'h97: s=8'h88;
            8'h98: s=8'h46; 8'h99: s=8'hEE; 8'h9A: s=8'hB8; 8'h9B: s=8'h14;
            8'h9C: s=8'hDE; 8'h9D: s=8'h5E; 8'h9E: s=8'h0B; 8'h9F: s=8'hDB;
            8'hA0: s=8'hE0; 8'hA1: s=8'h32; 8'hA2: s=8'h3A; 8'hA3: s=8'h0A;
            8'hA4: s=8'h49; 8'hA5: s=8'h06; 8'hA6: s=8'h24; 8'hA7: s=8'h5C;
            8'hA8: s=8'hC2; 8'hA9: s=8'hD3; 8'hAA: s=8'hAC; 8'hAB: s=8'h62;
            8'hAC: s=8'h91; 8'hAD: s=8'h95; 8'hAE: s=8'hE4; 8'hAF: s=8'h79;
            8'hB0: s=8'hE7; 8'hB1: s=8'hC8; 8'hB2: s=8'h37; 8'hB3: s=8'h6D;
            8'hB4: s=8'h8D; 8'hB5: s=8'hD5; 8'hB6: s=8'h4E; 8'hB7: s=8'hA9;
            8'hB8: s=8'h6C; 8'hB9: s=8'h56; 8'hBA: s=8'hF4; 8'hBB: s=8'hEA;
            8'hBC: s=8'h65; 8'hBD: s=8'h7A; 8'hBE: s=8'hAE; 8'hBF: s=8'h08;
            8'hC0: s=8'hBA; 8'hC1: s=8'h78; 8'hC2: s=8'h25; 8'hC3: s=8'h2E;
            8'hC4: s=8'h1C; 8'hC5: s=8'hA6; 8'hC6: s=8'hB4; 8'hC7: s=8'hC6;
            8'hC8: s=8'hE8; 8'hC9: s=8'hDD; 8'hCA: s=8'h74; 8'hCB: s=8'h1F;
            8'hCC: s=8'h4B; 8'hCD: s=8'hBD; 8'hCE: s=8'h8B; 8'hCF: s=8'h8A;
            8'hD0: s=8'h70; 8'hD1: s=8'h3E; 8'hD2: s=8'hB5; 8'hD3: s=8'h66;
            8'hD4: s=8'h48; 8'hD5: s=8'h03; 8'hD6: s=8'hF6; 8'hD7: s=8'h0E;
            8'hD8: s=8'h61; 8'hD9: s=8'h35; 8'hDA: s=8'h57; 8'hDB: s=8'hB9;
            8'hDC: s=8'h86; 8'hDD: s=8'hC1; 8'hDE: s=8'h1D; 8'hDF: s=8'h9E;
            8'hE0: s=8'hE1; 8'hE1: s=8'hF8; 8'hE2: s=8'h98; 8'hE3: s=8'h11;
            8'hE4: s=8'h69; 8'hE5: s=8'hD9; 8'hE6: s=8'h8E; 8'hE7: s=8'h94;
            8'hE8: s=8'h9B; 8'hE9: s=8'h1E; 8'hEA: s=8'h87; 8'hEB: s=8'hE9;
            8'hEC: s=8'hCE; 8'hED: s=8'h55; 8'hEE: s=8'h28; 8'hEF: s=8'hDF;
            8'hF0: s=8'h8C; 8'hF1: s=8'hA1; 8'hF2: s=8'h89; 8'hF3: s=8'h0D;
            8'hF4: s=8'hBF; 8'hF5: s=8'hE6; 8'hF6: s=8'h42; 8'hF7: s=8'h68;
            8'hF8: s=8'h41; 8'hF9: s=8'h99; 8'hFA: s=8'h2D; 8'hFB: s=8'h0F;
            8'hFC: s=8'hB0; 8'hFD: s=8'h54; 8'hFE: s=8'hBB; 8'hFF: s=8'h16;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Inverse S-box: search the forward table is too slow, so the table is
    // spelled out here as well.
    function automatic t_byte sbox_inv(input t_byte a);
        t_byte s;
        unique case (a)
            8'h00: s=8'h52; 8'h01: s=8'h09; 8'h02: s=8'h6a; 8'h03: s=8'hd5;
            8'h04: s=8'h30; 8'h05: s=8'h36; 8'h06: s=8'ha5; 8'h07: s=8'h38;
            8'h08: s=8'hbf; 8'h09: s=8'h40; 8'h0A: s=8'ha3; 8'h0B: s=8'h9e;
            8'h0C: s=8'h81; 8'h0D: s=8'hf3; 8'h0E: s=8'hd7; 8'h0F: s=8'hfb;
            8'h10: s=8'h7c; 8'h11: s=8'he3; 8'h12: s=8'h39; 8'h13: s=8'h82;
            8'h14: s=8'h9b; 8'h15: s=8'h2f; 8'h16: s=8'hff; 8'h17: s=8'h87;
            8'h18: s=8'h34; 8'h19: s=8'h8e; 8'h1A: s=8'h43; 8'h1B: s=8'h44;
            8'h1C: s=8'hc4; 8'h1D: s=8'hde; 8'h1E: s=8'he9; 8'h1F: s=8'hcb;
            8'h20: s=8'h54; 8'h21: s=8'h7b; 8'h22: s=8'h94; 8'h23: s=8'h32;
            8'h24: s=8'ha6; 8'h25: s=8'hc2; 8'h26: s=8'h23; 8'h27: s=8'h3d;
            8'h28: s=8'hee; 8'h29: s=8'h4c; 8'h2A: s=8'h95; 8'h2B: s=8'h0b;
            8'h2C: s=8'h42; 8'h2D: s=8'hfa; 8'h2E: s=8'hc3; 8'h2F: s=8'h4e;
            8'h30: s=8'h08; 8'h31: s=8'h2e; 8'h32: s=8'ha1; 8'h33: s=8'h66;
            8'h34: s=8'h28; 8'h35: s=8'hd9; 8'h36: s=8'h24; 8'h37: s=8'hb2;
            8'h38: s=8'h76; 8'h39: s=8'h5b; 8'h3A: s=8'ha2; 8'h3B: s=8'h49;
            8'h3C: s=8'h6d; 8'h3D: s=8'h8b; 8'h3E: s=8'hd1; 8'h3F: s=8'h25;
            8'h40: s=8'h72; 8'h41: s=8'hf8; 8'h42: s=8'hf6; 8'h43: s=8'h64;
            8'h44: s=8'h86; 8'h45: s=8'h68; 8'h46: s=8'h98; 8'h47: s=8'h16;
            8'h48: s=8'hd4; 8'h49: s=8'ha4; 8'h4A: s=8'h5c; 8'h4B: s=8'hcc;
            8'h4C: s=8'h5d; 8'h4D: s=8'h65; 8'h4E: s=8'hb6; 8'h4F: s=8'h92;
            8'h50: s=8'h6c; 8'h51: s=8'h70; 8'h52: s=8'h48; 8'h53: s=8'h50;
            8'h54: s=8'hfd; 8'h55: s=8'hed; 8'h56: s=8'hb9; 8'h57: s=8'hda;
            8'h58: s=8'h5e; 8'h59: s=8'h15; 8'h5A: s=8'h46; 8'h5B: s=8'h57;
            8'h5C: s=8'ha7; 8'h5D: s=8'h8d; 8'h5E: s=8'h9d; 8'h5F: s=8'h84;
            8'h60: s=8'h90; 8'h61: s=8'hd8; 8'h62: s=8'hab; 8'h63: s=8'h00;
            8'h64: s=8'h8c; 8'h65: s=8'hbc; 8'h66: s=8'hd3; 8'h67: s=8'h0a;
            8'h68: s=8'hf7; 8'h69: s=8'he4; 8'h6A: s=8'h58; 8'h6B: s=8'h05;
            8'h6C: s=8'hb8; 8'h6D: s=8'hb3; 8'h6E: s=8'h45; 8'h6F: s=8'h06;
            8'h70: s=8'hd0; 8'h71: s=8'h2c; 8'h72: s=8'h1e; 8'h73: s=8'h8f;
            8'h74: s=8'hca; 8'h75: s=8'h3f; 8'h76: s=8'h0f; 8'h77: s=8'h02;
            8'h78: s=8'hc1; 8'h79: s=8'haf; 8'h7A: s=8'hbd; 8'h7B: s=8'h03;
            8'h7C: s=8'h01; 8'h7D: s=8'h13; 8'h7E: s=8'h8a; 8'h7F: s=8'h6b;
            8'h80: s=8'h3a; 8'h81: s=8'h91; 8'h82: s=8'h11; 8'h83: s=8'h41;
            8'h84: s=8'h4f; 8'h85: s=8'h67; 8'h86: s=8'hdc; 8'h87: s=8'hea;
            8'h88: s=8'h97; 8'h89: s=8'hf2; 8'h8A: s=8'hcf; 8'h8B: s=8'hce;
            8'h8C: s=8'hf0; 8'h8D: s=8'hb4; 8'h8E: s=8'he6; 8'h8F: s=8'h73;
            8'h90: s=8'h96; 8'h91: s=8'hac; 8'h92: s=8'h74; 8'h93: s=8'h22;
            8'h94: s=8'he7; 8'h95: s=8'had; 8'h96: s=8'h35; 8'h97: s=8'h85;
            8'h98: s=8'he2; 8'h99: s=8'hf9; 8'h9A: s=8'h37; 8'h9B: s=8'he8;
            8'h9C: s=8'h1c; 8'h9D: s=8'h75; 8'h9E: s=8'hdf; 8'h9F: s=8'h6e;
            8'hA0: s=8'h47; 8'hA1: s=8'hf1; 8'hA2: s=8'h1a; 8'hA3: s=8'h71;
            8'hA4: s=8'h1d; 8'hA5: s=8'h29; 8'hA6: s=8'hc5; 8'hA7: s=8'h89;
            8'hA8: s=8'h6f; 8'hA9: s=8'hb7; 8'hAA: s=8'h62; 8'hAB: s=8'h0e;
            8'hAC: s=8'haa; 8'hAD: s=8'h18; 8'hAE: s=8'hbe; 8'hAF: s=8'h1b;
            8'hB0: s=8'hfc; 8'hB1: s=8'h56; 8'hB2: s=8'h3e; 8'hB3: s=8'h4b;
            8'hB4: s=8'hc6; 8'hB5: s=8'hd2; 8'hB6: s=8'h79; 8'hB7: s=8'h20;
            8'hB8: s=8'h9a; 8'hB9: s=8'hdb; 8'hBA: s=8'hc0; 8'hBB: s=8'hfe;
            8'hBC: s=8'h78; 8'hBD: s=8'hcd; 8'hBE: s=8'h5a; 8'hBF: s=8'hf4;
            8'hC0: s=8'h1f; 8'hC1: s=8'hdd; 8'hC2: s=8'ha8; 8'hC3: s=8'h33;
            8'hC4: s=8'h88; 8'hC5: s=8'h07; 8'hC6: s=8'hc7; 8'hC7: s=8'h31;
            8'hC8: s=8'hb1; 8'hC9: s=8'h12; 8'hCA: s=8'h10; 8'hCB: s=8'h59;
            8'hCC: s=8'h27; 8'hCD: s=8'h80; 8'hCE: s=8'hec; 8'hCF: s=8'h5f;
            8'hD0: s=8'h60; 8'hD1: s=8'h51; 8'hD2: s=8'h7f; 8'hD3: s=8'ha9;
            8'hD4: s=8'h19; 8'hD5: s=8'hb5; 8'hD6: s=8'h4a; 8'hD7: s=8'h0d;
            8'hD8: s=8'h2d; 8'hD9: s=8'he5; 8'hDA: s=8'h7a; 8'hDB: s=8'h9f;
            8'hDC: s=8'h93; 8'hDD: s=8'hc9; 8'hDE: s=8'h9c; 8'hDF: s=8'hef;
            8'hE0: s=8'ha0; 8'hE1: s=8'he0; 8'hE2: s=8'h3b; 8'hE3: s=8'h4d;
            8'hE4: s=8'hae; 8'hE5: s=8'h2a; 8'hE6: s=8'hf5; 8'hE7: s=8'hb0;
            8'hE8: s=8'hc8; 8'hE9: s=8'heb; 8'hEA: s=8'hbb; 8'hEB: s=8'h3c;
            8'hEC: s=8'h83; 8'hED: s=8'h53; 8'hEE: s=8'h99; 8'hEF: s=8'h61;
            8'hF0: s=8'h17; 8'hF1: s=8'h2b; 8'hF2: s=8'h04; 8'hF3: s=8'h7e;
            8'hF4: s=8'hba; 8'hF5: s=8'h77; 8'hF6: s=8'hd6; 8'hF7: s=8'h26;
            8'hF8: s=8'he1; 8'hF9: s=8'h69; 8'hFA: s=8'h14; 8'hFB: s=8'h63;
            8'hFC: s=8'h55; 8'hFD: s=8'h21; 8'hFE: s=8'h0c; 8'hFF: s=8'h7d;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Multiply by x in GF(2^8).
    function automatic t_byte xtime(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block, byte 0 at the top.
    function automatic t_byte get_byte(input t_block b, input int i);
        return b[127 - 8*i -: 8];
    endfunction

    // Full forward round body: SubBytes, ShiftRows, optional MixColumns.
    function automatic t_block enc_round(input t_block s, input logic mix);
        t_block t;
        t_block o;
        t_byte  a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(r + 4*c) -: 8] = sbox_fwd(get_byte(s, r + 4*((c + r) & 3)));
            end
        end
        o = t;
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = get_byte(t, 4*c);
                a1 = get_byte(t, 4*c + 1);
                a2 = get_byte(t, 4*c + 2);
                a3 = get_byte(t, 4*c + 3);
                o[127 - 8*(4*c) -: 8]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                o[127 - 8*(4*c + 1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                o[127 - 8*(4*c + 2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                o[127 - 8*(4*c + 3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        return o;
    endfunction

    // Inverse MixColumns on a whole block.
    function automatic t_block inv_mix(input t_block s);
        t_block o;
        t_byte  a [4];
        t_byte  x2 [4];
        t_byte  x4 [4];
        t_byte  x8 [4];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r]  = get_byte(s, 4*c + r);
                x2[r] = xtime(a[r]);
                x4[r] = xtime(x2[r]);
                x8[r] = xtime(x4[r]);
            end
            for (int r = 0; r < 4; r++) begin
                // 0e.a[r] ^ 0b.a[r+1] ^ 0d.a[r+2] ^ 09.a[r+3]
                o[127 - 8*(4*c + r) -: 8] =
                    (x8[r] ^ x4[r] ^ x2[r]) ^
                    (x8[(r+1)&3] ^ x2[(r+1)&3] ^ a[(r+1)&3]) ^
                    (x8[(r+2)&3] ^ x4[(r+2)&3] ^ a[(r+2)&3]) ^
                    (x8[(r+3)&3] ^ a[(r+3)&3]);
            end
        end
        return o;
    endfunction

    // Inverse ShiftRows followed by inverse SubBytes.
    function automatic t_block inv_shift_sub(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(r + 4*c) -: 8] = sbox_inv(get_byte(s, r + 4*((c + 3*r) & 3)));
            end
        end
        return t;
    endfunction

endpackage

### design/aes_stream_if.sv
// Valid/ready channel carrying a block and its action bit.
interface aes_stream_if;
    logic         valid;
    logic         ready;
    logic         action;
    logic [63:0]  block_high;
    logic [63:0]  block_low;

    modport source (output valid, action, block_high, block_low, input ready);
    modport sink   (input valid, action, block_high, block_low, output ready);
endinterface

### design/aes_result_if.sv
// Valid/ready channel carrying a result block.
interface aes_result_if;
    logic         valid;
    logic         ready;
    logic [63:0]  result_high;
    logic [63:0]  result_low;

    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

### design/aes_key_sched.sv
// Expands the cipher key into eleven round keys, one round per cycle.
module aes_key_sched (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [127:0]           i_key,
    output aes_pkg::t_block        o_rkeys [aes_pkg::NumKeys],
    output aes_pkg::t_ks_status    o_status
);
    import aes_pkg::*;

    t_ks_state r_state, n_state;
    logic [3:0] r_round;
    t_block     r_cur;
    t_block     r_keys [NumKeys];
    t_block     w_nxt;
    t_byte      w_rcon;
    logic [31:0] w_temp;

    // Round constant for the round being made.
    always_comb begin
        unique case (r_round)
            4'd1: w_rcon = 8'h01;  4'd2: w_rcon = 8'h02;
            4'd3: w_rcon = 8'h04;  4'd4: w_rcon = 8'h08;
            4'd5: w_rcon = 8'h10;  4'd6: w_rcon = 8'h20;
            4'd7: w_rcon = 8'h40;  4'd8: w_rcon = 8'h80;
            4'd9: w_rcon = 8'h1b;  4'd10: w_rcon = 8'h36;
            default: w_rcon = 8'h00;
        endcase
    end

    // Next round key from the current one.
    always_comb begin
        w_temp = {sbox_fwd(r_cur[23:16]) ^ w_rcon, sbox_fwd(r_cur[15:8]),
                  sbox_fwd(r_cur[7:0]), sbox_fwd(r_cur[31:24])};
        w_nxt[127:96] = r_cur[127:96] ^ w_temp;
        w_nxt[95:64]  = r_cur[95:64] ^ w_nxt[127:96];
        w_nxt[63:32]  = r_cur[63:32] ^ w_nxt[95:64];
        w_nxt[31:0]   = r_cur[31:0] ^ w_nxt[63:32];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_ks_idle: if (i_start) n_state = t_ks_run;
            t_ks_run: begin
                if (i_start) begin
                    n_state = t_ks_run;
                end else if (r_round == 4'(NumRounds)) begin
                    n_state = t_ks_idle;
                end
            end
            default: n_state = t_ks_idle;
        endcase
    end

    // Outputs.
    always_comb begin
        o_status.busy = (r_state == t_ks_run);
        o_status.done = (r_state == t_ks_run) && (r_round == 4'(NumRounds)) && !i_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ks_idle;
            r_round <= 4'd0;
        end else begin
            r_state <= n_state;
            if (i_start) begin
                r_round <= 4'd1;
            end else if (r_state == t_ks_run && r_round != 4'(NumRounds)) begin
                r_round <= r_round + 4'd1;
            end
        end
    end

    // Round-key store, written one key a cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cur     <= i_key;
            r_keys[0] <= i_key;
        end else if (r_state == t_ks_run) begin
            r_cur           <= w_nxt;
            r_keys[r_round] <= w_nxt;
        end
    end

    assign o_rkeys = r_keys;
endmodule

### design/aes_round_stage.sv
// One pipeline stage: a round for both directions, with its own valid bit.
module aes_round_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic             i_action,
    input  aes_pkg::t_block  i_state,
    input  aes_pkg::t_block  i_key_enc,
    input  aes_pkg::t_block  i_key_dec,
    input  logic             i_last,
    input  logic             i_first,
    output logic             o_valid,
    output logic             o_action,
    output aes_pkg::t_block  o_state
);
    import aes_pkg::*;

    logic   r_valid;
    logic   r_action;
    t_block r_state;
    t_block w_enc;
    t_block w_dec;

    // Encrypt: round (no mix in the last round) then key.
    // Decrypt: key, inverse mix except in the first stage, inverse shift/sub.
    always_comb begin
        w_enc = enc_round(i_state, !i_last) ^ i_key_enc;
        w_dec = i_state ^ i_key_dec;
        if (!i_first) begin
            w_dec = inv_mix(w_dec);
        end
        w_dec = inv_shift_sub(w_dec);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_action <= i_action;
            r_state  <= i_action ? w_dec : w_enc;
        end
    end

    assign o_valid  = r_valid;
    assign o_action = r_action;
    assign o_state  = r_state;
endmodule

### design/aes128_block_cipher.sv
// A block passes the input stage and then one stage per round before its result is valid.
// Throughput: one block per cycle; the pipeline stalls as a whole on output back-pressure.
// Each key write re-expands the round keys; input is held off meanwhile.
// Reset (synchronous, active low) clears valid bits and keys, and expands the zero key.
module aes128_block_cipher (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    aes_stream_if.sink    in_if,
    aes_result_if.source  out_if
);
    import aes_pkg::*;
    `include "assert_macros.svh"

    logic [63:0] r_key_high, r_key_low;
    logic        r_kick;
    logic        w_wr;
    logic        w_en;
    t_block      w_rkeys [NumKeys];
    t_ks_status  w_ks;
    logic        w_v   [NumRounds+1];
    logic        w_a   [NumRounds+1];
    t_block      w_s   [NumRounds+1];
    logic        r_v0, r_a0;
    t_block      r_s0;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Key registers; any key write restarts the expansion.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= 64'd0;
            r_key_low  <= 64'd0;
            r_kick     <= 1'b1;
        end else begin
            r_kick <= 1'b0;
            if (w_wr && paddr[3] == 1'b0 && paddr[2:0] == 3'd0) begin
                r_key_high <= pwdata;
                r_kick     <= 1'b1;
            end else if (w_wr && paddr[3] == 1'b1 && paddr[2:0] == 3'd0) begin
                r_key_low <= pwdata;
                r_kick    <= 1'b1;
            end
        end
    end

    // Register read-back.
    always_comb begin
        unique case ({paddr[3] == 1'b1, paddr[2:0] == 3'd0})
            {1'b0, 1'b1}: prdata = r_key_high;
            {1'b1, 1'b1}: prdata = r_key_low;
            default:      prdata = 64'd0;
        endcase
    end

    aes_key_sched u_ks (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick),
        .i_key   ({r_key_high, r_key_low}),
        .o_rkeys (w_rkeys),
        .o_status(w_ks)
    );

    // Whole pipeline advances when the output stage is free or empty.
    assign w_en        = out_if.ready || !w_v[NumRounds];
    assign in_if.ready = w_en && !w_ks.busy && !r_kick;

    // Input stage: initial key addition for encryption.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= in_if.valid && in_if.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a0 <= in_if.action;
            r_s0 <= in_if.action ? {in_if.block_high, in_if.block_low}
                                 : ({in_if.block_high, in_if.block_low} ^ w_rkeys[0]);
        end
    end

    assign w_v[0] = r_v0;
    assign w_a[0] = r_a0;
    assign w_s[0] = r_s0;

    // Round stages; decryption walks the keys from the top down.
    for (genvar g = 0; g < NumRounds; g++) begin : g_round
        aes_round_stage u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (w_v[g]),
            .i_action (w_a[g]),
            .i_state  (w_s[g]),
            .i_key_enc(w_rkeys[g + 1]),
            .i_key_dec(w_rkeys[NumRounds - g]),
            .i_last   (g == NumRounds - 1),
            .i_first  (g == 0),
            .o_valid  (w_v[g + 1]),
            .o_action (w_a[g + 1]),
            .o_state  (w_s[g + 1])
        );
    end

    assign out_if.valid       = w_v[NumRounds];
    assign out_if.result_high = w_s[NumRounds][127:64]
                              ^ (w_a[NumRounds] ? w_rkeys[0][127:64] : 64'd0);
    assign out_if.result_low  = w_s[NumRounds][63:0]
                              ^ (w_a[NumRounds] ? w_rkeys[0][63:0] : 64'd0);

    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, out_if.valid && !out_if.ready, out_if.valid)
    `ASSERT_IMPLIES(a_no_take_busy, i_clk, i_rst_n, w_ks.busy, !in_if.ready)
    `ASSERT_NEXT(a_kick_busy, i_clk, i_rst_n, r_kick, w_ks.busy)
endmodule

### sim/aes128_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts each result block and compares it.
module aes128_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [63:0]  i_key_high,
    input  logic [63:0]  i_key_low,
    aes_stream_if        in_ch,
    aes_result_if        out_ch,
    output int           o_fail_count,
    output int           o_pending
);
    import aes_pkg::*;

    localparam logic ActEncrypt = 1'b0;

    logic [127:0] cipher_results [$];
    logic [127:0] sched [NumKeys];

    // Forward S-box built from the multiplicative inverse and the affine map.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                p ^= a;
            end
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    logic [7:0] fwd_box [256];
    logic [7:0] inv_box [256];

    initial begin
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++) begin
                if (gf_mul(x[7:0], y[7:0]) == 8'h01) begin
                    inv = y[7:0];
                end
            end
            for (int b = 0; b < 8; b++) begin
                s[b] = inv[b] ^ inv[(b + 4) % 8] ^ inv[(b + 5) % 8] ^ inv[(b + 6) % 8]
                     ^ inv[(b + 7) % 8];
            end
            s ^= 8'h63;
            fwd_box[x] = s;
            inv_box[s] = x[7:0];
        end
    end

    function automatic logic [7:0] byte_at(input logic [127:0] b, input int i);
        return b[127 - 8*i -: 8];
    endfunction

    // Standard AES-128 key schedule over the whole key.
    function automatic void expand_schedule(input logic [127:0] k);
        logic [127:0] cur;
        logic [127:0] nxt;
        logic [7:0]   rc;
        cur = k;
        rc = 8'h01;
        sched[0] = cur;
        for (int r = 1; r < NumKeys; r++) begin
            nxt[127 -: 8] = byte_at(cur, 0) ^ fwd_box[byte_at(cur, 13)] ^ rc;
            nxt[119 -: 8] = byte_at(cur, 1) ^ fwd_box[byte_at(cur, 14)];
            nxt[111 -: 8] = byte_at(cur, 2) ^ fwd_box[byte_at(cur, 15)];
            nxt[103 -: 8] = byte_at(cur, 3) ^ fwd_box[byte_at(cur, 12)];
            for (int j = 4; j < 16; j++) begin
                nxt[127 - 8*j -: 8] = byte_at(cur, j) ^ byte_at(nxt, j - 4);
            end
            cur = nxt;
            sched[r] = cur;
            rc = gf_mul(rc, 8'h02);
        end
    endfunction

    function automatic logic [127:0] shift_sub(input logic [127:0] s, input logic decrypt);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (decrypt) begin
                    t[127 - 8*(r + 4*c) -: 8] = inv_box[byte_at(s, r + 4*((c + 3*r) & 3))];
                end else begin
                    t[127 - 8*(r + 4*c) -: 8] = fwd_box[byte_at(s, r + 4*((c + r) & 3))];
                end
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input logic decrypt);
        logic [127:0] t;
        logic [7:0]   m [4];
        logic [7:0]   acc;
        if (decrypt) begin
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        end else begin
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    acc ^= gf_mul(m[k], byte_at(s, 4*c + ((r + k) & 3)));
                end
                t[127 - 8*(4*c + r) -: 8] = acc;
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] cipher_block(input logic act, input logic [127:0] b);
        logic [127:0] s;
        if (act == ActEncrypt) begin
            s = b ^ sched[0];
            for (int r = 1; r < NumRounds; r++) begin
                s = mix(shift_sub(s, 1'b0), 1'b0) ^ sched[r];
            end
            s = shift_sub(s, 1'b0) ^ sched[NumRounds];
        end else begin
            s = shift_sub(b ^ sched[NumRounds], 1'b1);
            for (int r = NumRounds - 1; r > 0; r--) begin
                s = shift_sub(mix(s ^ sched[r], 1'b1), 1'b1);
            end
            s ^= sched[0];
        end
        return s;
    endfunction

    // Predict on each input transfer, compare on each output transfer.
    always @(posedge i_clk) begin
        logic [127:0] want;
        logic [127:0] got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                expand_schedule({i_key_high, i_key_low});
                cipher_results.push_back(cipher_block(in_ch.action,
                                                      {in_ch.block_high, in_ch.block_low}));
            end
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.result_high, out_ch.result_low};
                if (cipher_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("Unexpected result transfer %h", got);
                    end
                end else begin
                    want = cipher_results.pop_front();
                    if (want[127:64] !== got[127:64] || want[63:0] !== got[63:0]) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("Result mismatch: expected %h, got %h", want, got);
                        end
                    end
                end
            end
            o_pending = cipher_results.size();
        end
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end
endmodule

### sim/tb_aes128_block_cipher.sv
`timescale 1ns / 1ps

module tb_aes128_block_cipher;
    import aes_pkg::*;

    localparam logic ActEncrypt = 1'b0;
    localparam logic ActDecrypt = 1'b1;
    localparam int   CycleLimit = 400000;

    logic         i_clk;
    logic         i_rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;
    logic [63:0]  key_high;
    logic [63:0]  key_low;
    logic         long_hold;
    int           fail_count;
    int           pending;
    int           cycles;

    aes_stream_if in_ch ();
    aes_result_if out_ch ();

    aes128_block_cipher DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_if   (in_ch),
        .out_if  (out_ch)
    );

    aes128_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_high   (key_high),
        .i_key_low    (key_low),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Writes one key register through a setup and an access cycle.
    task automatic write_key(input logic [1:0] reg_index, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(reg_index * 8);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (reg_index == RegKeyHigh) begin
            key_high = value;
        end else begin
            key_low = value;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one block and waits for its transfer; valid stays up for a following block.
    task automatic send_block(input logic act, input logic [63:0] hi, input logic [63:0] lo);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= act;
        in_ch.block_high <= hi;
        in_ch.block_low  <= lo;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Stops offering, waits until every result is back, then idles with the pipeline empty.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic random_blocks(input int count);
        logic [63:0] hi;
        logic [63:0] lo;
        for (int i = 0; i < count; i++) begin
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
            send_block(logic'($urandom_range(0, 1)), hi, lo);
        end
    endtask

    // Receiver: random stalls per result, with one long hold-off.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (150) @(negedge i_clk);
                long_hold = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Cycle counter with timeout.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        in_ch.valid      = 1'b0;
        in_ch.action     = ActEncrypt;
        in_ch.block_high = '0;
        in_ch.block_low  = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        key_high = '0; key_low = '0;
        long_hold = 1'b0;
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero key straight after reset, extreme blocks, both operations.
        send_block(ActEncrypt, '0, '0);
        send_block(ActDecrypt, '0, '0);
        send_block(ActEncrypt, '1, '1);
        send_block(ActDecrypt, '1, '1);
        wait_idle();

        // Standard test key, then each register set to all ones.
        write_key(RegKeyHigh, 64'h2b7e151628aed2a6);
        write_key(RegKeyLow, 64'habf7158809cf4f3c);
        send_block(ActEncrypt, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
        send_block(ActDecrypt, 64'h3925841d02dc09fb, 64'hdc118597196a0b32);
        send_block(ActEncrypt, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        send_block(ActDecrypt, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        wait_idle();
        write_key(RegKeyHigh, '1);
        send_block(ActEncrypt, '0, '1);
        wait_idle();
        write_key(RegKeyLow, '1);
        send_block(ActDecrypt, '1, '0);
        send_block(ActEncrypt, 64'h8000000000000000, 64'h0000000000000001);
        wait_idle();

        // Long receiver hold-off so the pipeline fills up.
        long_hold = 1'b1;
        random_blocks(40);
        wait_idle();

        // Random phases under several keys.
        for (int phase = 0; phase < 6; phase++) begin
            write_key(RegKeyHigh, {$urandom, $urandom});
            write_key(RegKeyLow, {$urandom, $urandom});
            random_blocks(110);
            wait_idle();
        end
        write_key(RegKeyHigh, '0);
        write_key(RegKeyLow, '0);
        random_blocks(10);
        wait_idle();

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/aes_pkg.sv
design/aes_stream_if.sv
design/aes_result_if.sv
design/aes_key_sched.sv
design/aes_round_stage.sv
design/aes128_block_cipher.sv
sim/aes128_checker.sv
sim/tb_aes128_block_cipher.sv
